/* rtl/krt_pkg.sv */
`default_nettype none

package krt_pkg;

  // Default number of tracked key slots
  localparam int unsigned KeySlotsDefault = 6;
  // Key slots shown in a report
  localparam int unsigned ReportSlots = 6;

  // Modifier usage range and largest usage that fits a report byte
  localparam logic [15:0] ModFirst = 16'h00E0;
  localparam logic [15:0] ModLast  = 16'h00E7;
  localparam logic [15:0] UsageMax = 16'h00FF;

  // Event operation codes
  typedef enum logic {
    OP_KEY         = 1'b0,
    OP_RELEASE_ALL = 1'b1
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] usage;
    logic        down;
  } event_t;

  typedef struct packed {
    logic [7:0] modifier_mask;
    logic [7:0] slot_key_0;
    logic [7:0] slot_key_1;
    logic [7:0] slot_key_2;
    logic [7:0] slot_key_3;
    logic [7:0] slot_key_4;
    logic [7:0] slot_key_5;
  } report_t;

endpackage

`default_nettype wire

/* rtl/krt_event_if.sv */
`default_nettype none

interface krt_event_if;
  logic            valid;
  logic            ready;
  krt_pkg::event_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/krt_report_if.sv */
`default_nettype none

interface krt_report_if;
  logic             valid;
  logic             ready;
  krt_pkg::report_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/keyboard_rollover_report_tracker.sv */
// Keyboard report tracker for a boot-protocol keyboard.
// evt_i carries key events (op, usage, down); rpt_o carries one keyboard
// report (modifier byte and six key slots) for each event that changes or
// reports state. Modifier usages set or clear one modifier bit, other
// usages 1..255 fill or empty key slots, usage 0 and usages above 255
// give no report. A release-all event clears everything and reports.
// An item taken sits in the input register, and its report is in the output
// register once the input register advances.
// One item per cycle while the receiver takes reports; the slot compare,
// first-free pick and the state update are combinational between the input
// register and the state and report registers.
// Reset clears the held modifiers, all key slots and both valid flags.
// When the receiver stalls, the report holds in the output register, the
// input register holds its item, and evt_i.ready drops once both are full.
// KEY_SLOTS sets how many keys are tracked; only the first six are shown.
`default_nettype none

module keyboard_rollover_report_tracker #(
  parameter int unsigned KEY_SLOTS = krt_pkg::KeySlotsDefault
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  krt_event_if.sink   evt_i,
  krt_report_if.source rpt_o
);
  import krt_pkg::*;

  // Input register
  logic   in_valid_q;
  event_t in_q;

  // Tracked state
  logic [7:0]                  mods_q, mods_d;
  logic [KEY_SLOTS-1:0][7:0]   slots_q, slots_d;

  // Output register
  logic    out_valid_q, out_valid_d;
  report_t out_q, out_d;

  logic                 advance;
  logic                 is_mod, is_key, has_result;
  logic [7:0]           key;
  logic [7:0]           mod_bit;
  logic [KEY_SLOTS-1:0] match_vec, free_vec, match_first, free_first;
  logic                 any_match;
  logic [ReportSlots-1:0][7:0] rep_slot;

  // Input register moves on when the report register can take a result
  assign advance     = in_valid_q && (!out_valid_q || rpt_o.ready);
  assign evt_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (evt_i.ready) begin
      in_valid_q <= evt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_i.ready && evt_i.valid) begin
      in_q <= evt_i.payload;
    end
  end

  // Decode the usage
  assign key     = in_q.usage[7:0];
  assign mod_bit = 8'd1 << in_q.usage[2:0];
  assign is_mod  = (in_q.usage >= ModFirst) && (in_q.usage <= ModLast);
  assign is_key  = !is_mod && (in_q.usage != 16'd0) && (in_q.usage <= UsageMax);
  assign has_result = (in_q.op == OP_RELEASE_ALL) || is_mod || is_key;

  // Compare all slots and pick the first match and the first empty slot
  always_comb begin
    for (int i = 0; i < KEY_SLOTS; i++) begin
      match_vec[i] = (slots_q[i] == key);
      free_vec[i]  = (slots_q[i] == 8'd0);
    end
  end

  assign match_first = match_vec & (~match_vec + KEY_SLOTS'(1));
  assign free_first  = free_vec & (~free_vec + KEY_SLOTS'(1));
  assign any_match   = |match_vec;

  // Next state
  always_comb begin
    mods_d  = mods_q;
    slots_d = slots_q;
    if (in_q.op == OP_RELEASE_ALL) begin
      mods_d  = 8'd0;
      slots_d = '0;
    end else if (is_mod) begin
      mods_d = in_q.down ? (mods_q | mod_bit) : (mods_q & ~mod_bit);
    end else if (is_key) begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
        if (in_q.down) begin
          if (!any_match && free_first[i]) begin
            slots_d[i] = key;
          end
        end else if (match_first[i]) begin
          slots_d[i] = 8'd0;
        end
      end
    end
  end

  // Shown slots: empty beyond the tracked count
  for (genvar g = 0; g < ReportSlots; g++) begin : g_rep
    if (g < KEY_SLOTS) begin : g_held
      assign rep_slot[g] = slots_d[g];
    end else begin : g_none
      assign rep_slot[g] = 8'd0;
    end
  end

  // Build the report
  always_comb begin
    out_d.modifier_mask = mods_d;
    out_d.slot_key_0    = rep_slot[0];
    out_d.slot_key_1    = rep_slot[1];
    out_d.slot_key_2    = rep_slot[2];
    out_d.slot_key_3    = rep_slot[3];
    out_d.slot_key_4    = rep_slot[4];
    out_d.slot_key_5    = rep_slot[5];
    out_valid_d = out_valid_q && !rpt_o.ready;
    if (advance && has_result) begin
      out_valid_d = 1'b1;
    end
  end

  // Update state and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mods_q      <= 8'd0;
      slots_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance) begin
        mods_q  <= mods_d;
        slots_q <= slots_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && has_result) begin
      out_q <= out_d;
    end
  end

  assign rpt_o.valid   = out_valid_q;
  assign rpt_o.payload = out_q;

`ifndef SYNTHESIS
  // A release-all leaves every modifier and slot empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (in_q.op == OP_RELEASE_ALL) |=> (mods_q == 8'd0) && (slots_q == '0))
    else $error("release-all did not clear state");

  // A press of a key already held changes no slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (in_q.op == OP_KEY) && is_key && in_q.down && any_match
    |=> $stable(slots_q))
    else $error("repeated press changed the slots");

  // An event without a report leaves state untouched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !has_result |=> $stable(mods_q) && $stable(slots_q))
    else $error("ignored usage changed state");

  // Input stalls only while the input register holds an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !evt_i.ready |-> in_valid_q && out_valid_q)
    else $error("input stalled without a pending item");
`endif

endmodule

`default_nettype wire
